/* hdl/b45_pkg.sv */
package b45_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [10:0] RADIX     = 11'd45;
    localparam logic [16:0] RADIX_SQ  = 17'd2025;

    typedef struct packed {
        logic       ok;
        logic [5:0] digit;
    } b45_digit_t;

    typedef struct packed {
        logic        two;
        logic        err;
        logic        eom;
        logic [15:0] value;
    } b45_cmd_t;

    function automatic b45_digit_t b45_map(input logic [15:0] code);
        b45_digit_t r;
        logic [6:0] c;
        c = code[6:0];
        r.ok    = 1'b1;
        r.digit = 6'd0;
        unique case (c) inside
            [7'd48:7'd57]: r.digit = 6'(c - 7'd48);
            [7'd65:7'd90]: r.digit = 6'(c - 7'd55);
            7'd32:         r.digit = 6'd36;
            7'd36:         r.digit = 6'd37;
            7'd37:         r.digit = 6'd38;
            7'd42:         r.digit = 6'd39;
            7'd43:         r.digit = 6'd40;
            7'd45:         r.digit = 6'd41;
            7'd46:         r.digit = 6'd42;
            7'd47:         r.digit = 6'd43;
            7'd58:         r.digit = 6'd44;
            default:       r.ok    = 1'b0;
        endcase
        if (code[15:7] != 9'd0)
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

/* hdl/b45_front.sv */
module b45_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_stall,
    input  logic [15:0]       char_code,
    input  logic              last_char,
    input  logic              full,
    output logic              push,
    output b45_pkg::b45_cmd_t cmd
);

    logic [1:0]  pos_reg, pos_next;
    logic [10:0] partial_reg, partial_next;
    logic        discard_reg, discard_next;

    b45_pkg::b45_digit_t dg;
    logic        accept;
    logic [10:0] pair;
    logic [16:0] n;

    assign char_stall = full;
    assign accept     = char_valid && !full;
    assign dg         = b45_pkg::b45_map(char_code);
    assign pair       = partial_reg + 11'(dg.digit) * b45_pkg::RADIX;
    assign n          = 17'(partial_reg) + 17'(dg.digit) * b45_pkg::RADIX_SQ;

    always_comb
    begin
        pos_next     = pos_reg;
        partial_next = partial_reg;
        discard_next = discard_reg;
        push         = 1'b0;
        cmd          = '0;
        if (accept)
        begin
            if (discard_reg)
            begin
                if (last_char)
                begin
                    pos_next     = 2'd0;
                    partial_next = 11'd0;
                    discard_next = 1'b0;
                end
            end
            else if (!dg.ok)
            begin
                push         = 1'b1;
                cmd.err      = 1'b1;
                cmd.eom      = 1'b1;
                pos_next     = 2'd0;
                partial_next = 11'd0;
                discard_next = !last_char;
            end
            else
            begin
                case (pos_reg)
                    2'd1:
                    begin
                        if (last_char)
                        begin
                            push         = 1'b1;
                            cmd.eom      = 1'b1;
                            pos_next     = 2'd0;
                            partial_next = 11'd0;
                            if (pair[10:8] != 3'd0)
                            begin
                                cmd.err = 1'b1;
                            end
                            else
                            begin
                                cmd.value = {8'd0, pair[7:0]};
                            end
                        end
                        else
                        begin
                            partial_next = pair;
                            pos_next     = 2'd2;
                        end
                    end
                    2'd2:
                    begin
                        push         = 1'b1;
                        pos_next     = 2'd0;
                        partial_next = 11'd0;
                        if (n[16])
                        begin
                            cmd.err      = 1'b1;
                            cmd.eom      = 1'b1;
                            discard_next = !last_char;
                        end
                        else
                        begin
                            cmd.two   = 1'b1;
                            cmd.eom   = last_char;
                            cmd.value = n[15:0];
                        end
                    end
                    default:
                    begin
                        if (last_char)
                        begin
                            push         = 1'b1;
                            cmd.err      = 1'b1;
                            cmd.eom      = 1'b1;
                            pos_next     = 2'd0;
                            partial_next = 11'd0;
                        end
                        else
                        begin
                            partial_next = 11'(dg.digit);
                            pos_next     = 2'd1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 2'd0;
            partial_reg <= 11'd0;
            discard_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            partial_reg <= partial_next;
            discard_reg <= discard_next;
        end
    end

    a_no_push_discard: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> !push)
        else $error("transfer produced a result while discarding");

    a_error_clears_group: assert property (@(posedge clk) disable iff (!rst_n)
        (push && cmd.err) |=> (pos_reg == 2'd0 && partial_reg == 11'd0))
        else $error("group not cleared after error");

endmodule

/* hdl/b45_fifo.sv */
module b45_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b45_pkg::b45_cmd_t push_data,
    input  logic              pop,
    output b45_pkg::b45_cmd_t pop_data,
    output logic              full,
    output logic              empty
);

    b45_pkg::b45_cmd_t mem_reg [b45_pkg::FIFO_DEPTH];
    logic [b45_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [b45_pkg::FIFO_CW-1:0] count_reg;

    assign full     = (count_reg == b45_pkg::FIFO_CW'(b45_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue underflow");

endmodule

/* hdl/b45_back.sv */
module b45_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  b45_pkg::b45_cmd_t pop_data,
    output logic              pop,
    output logic              byte_valid,
    input  logic              byte_stall,
    output logic [7:0]        data_byte,
    output logic              error,
    output logic              end_of_message
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       err_reg;
    logic       eom_reg;
    logic       pend_reg;
    logic [7:0] pend_data_reg;
    logic       pend_eom_reg;
    logic       load;

    assign load           = !valid_reg || !byte_stall;
    assign pop            = load && !pend_reg && !empty;
    assign byte_valid     = valid_reg;
    assign data_byte      = data_reg;
    assign error          = err_reg;
    assign end_of_message = eom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else
            begin
                valid_reg <= !empty;
                pend_reg  <= !empty && pop_data.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                data_reg <= pend_data_reg;
                err_reg  <= 1'b0;
                eom_reg  <= pend_eom_reg;
            end
            else if (pop_data.two)
            begin
                data_reg      <= pop_data.value[15:8];
                err_reg       <= 1'b0;
                eom_reg       <= 1'b0;
                pend_data_reg <= pop_data.value[7:0];
                pend_eom_reg  <= pop_data.eom;
            end
            else
            begin
                data_reg <= pop_data.value[7:0];
                err_reg  <= pop_data.err;
                eom_reg  <= pop_data.eom;
            end
        end
    end

    a_pending_after_high: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (valid_reg && !err_reg && !eom_reg))
        else $error("low byte pending without high byte transfer");

endmodule

/* hdl/base45_stream_decoder.sv */
// Streaming Base45 decoder.
// Input channel: one character per transfer (char_code, last_char), handshake
// char_valid / char_stall. last_char marks the final character of a message.
// Output channel: one byte per transfer (data_byte, error, end_of_message),
// handshake byte_valid / byte_stall.
// Each third character of a group yields two bytes (high, then low); a final
// pair yields one byte. A bad character, an overflowing group or a lone final
// character yields a single result with error and end_of_message set; the
// rest of that message up to last_char gives no output.
// Throughput: one character per cycle while char_stall is low. The output
// side sends one byte per cycle while byte_stall is low, so a full group of
// three characters gives two output bytes. A result passes through the queue
// and is registered in the output stage before it is valid; a low byte waits
// in a pending register and follows its high byte.
// A four-entry queue sits between the character front end and the byte
// output stage; char_stall rises only when that queue is full.
// While byte_stall is high the output holds its byte and the queue fills.
// Reset clears group state, queue and output valid; no clearing pass.
module base45_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [15:0] char_code,
    input  logic        last_char,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  data_byte,
    output logic        error,
    output logic        end_of_message
);

    b45_pkg::b45_cmd_t push_data;
    b45_pkg::b45_cmd_t pop_data;
    logic push;
    logic pop;
    logic full;
    logic empty;

    b45_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .full       (full),
        .push       (push),
        .cmd        (push_data)
    );

    b45_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    b45_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .empty          (empty),
        .pop_data       (pop_data),
        .pop            (pop),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .error          (error),
        .end_of_message (end_of_message)
    );

endmodule
